// ===== hw/rtl/adts_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adts_pkg: shared types, constants and helpers for the ADTS frame wrapper
// Holds the work entry passed from the decoder to the emitter, register
// indexes and the header byte builder.
// ----------------------------------------------------------------------------
package adts_pkg;

   // Register indexes on the csr port
   localparam logic [1:0] REG_AAC_PROFILE    = 2'd0;
   localparam logic [1:0] REG_FREQ_INDEX     = 2'd1;
   localparam logic [1:0] REG_CHANNEL_CONFIG = 2'd2;

   // Register reset values
   localparam logic [1:0] AAC_PROFILE_RST    = 2'd1;
   localparam logic [3:0] FREQ_INDEX_RST     = 4'd4;
   localparam logic [2:0] CHANNEL_CONFIG_RST = 3'd2;

   // Framing constants
   localparam int unsigned SIZE_W            = 21;
   localparam int unsigned FLEN_W            = 13;
   localparam logic [SIZE_W-1:0] MAX_SAMPLE  = 21'(1 << 20);
   localparam logic [SIZE_W-1:0] MAX_FRAME   = 21'h1FFF;
   localparam logic [SIZE_W-1:0] HDR_LEN     = 21'd7;
   localparam logic [7:0] SYNC_HI            = 8'hFF;
   localparam logic [7:0] SYNC_LO            = 8'hF1;
   localparam logic [4:0] FULLNESS_HI        = 5'h1F;
   localparam logic [7:0] FULLNESS_LO        = 8'hFC;
   localparam logic [2:0] HDR_LAST_IDX       = 3'd7;

   // One pending result group: a fault marker, a payload byte, or a header
   // followed by a payload byte
   typedef struct packed {
      logic              hdr;
      logic              fault;
      logic              last;
      logic [7:0]        data;
      logic [1:0]        profile;
      logic [3:0]        freq;
      logic [2:0]        chan;
      logic [FLEN_W-1:0] flen;
   } work_type;

   // Header byte at position idx (0 to 6)
   function automatic logic [7:0] hdr_byte(input work_type w, input logic [2:0] idx);
      logic [7:0] b;
      begin
         case (idx)
            3'd0:    b = SYNC_HI;
            3'd1:    b = SYNC_LO;
            3'd2:    b = {w.profile, w.freq, 1'b0, w.chan[2]};
            3'd3:    b = {w.chan[1:0], 4'd0, w.flen[12:11]};
            3'd4:    b = w.flen[10:3];
            3'd5:    b = {w.flen[2:0], FULLNESS_HI};
            3'd6:    b = FULLNESS_LO;
            default: b = w.data;
         endcase
         return b;
      end
   endfunction

endpackage

// ===== hw/rtl/adts_dec.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adts_dec: sample tracking and result decode
// Keeps the byte count of the current sample and the sticky fault, and
// turns each accepted byte into a work entry for the emitter.
// ----------------------------------------------------------------------------
module adts_dec (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         accept,
   input  logic [7:0]                   payload_byte,
   input  logic [adts_pkg::SIZE_W-1:0]  sample_bytes,
   input  logic [1:0]                   aac_profile,
   input  logic [3:0]                   freq_index,
   input  logic [2:0]                   channel_config,
   output logic                         load,
   output adts_pkg::work_type           entry
);

   logic [adts_pkg::SIZE_W-1:0] bytes_seen_ff, bytes_seen_in;
   logic                        failed_ff, failed_in;
   logic                        bad_size;
   logic                        is_last;
   logic                        fits;
   logic [adts_pkg::SIZE_W-1:0] flen;
   logic [adts_pkg::SIZE_W:0]   seen_next;

   // Classify the byte against its sample size
   always_comb begin
      bad_size  = (sample_bytes == '0) || (sample_bytes > adts_pkg::MAX_SAMPLE);
      flen      = sample_bytes + adts_pkg::HDR_LEN;
      fits      = (flen <= adts_pkg::MAX_FRAME);
      seen_next = {1'b0, bytes_seen_ff} + 22'd1;
      is_last   = (seen_next >= {1'b0, sample_bytes});
   end

   // Build the work entry
   always_comb begin
      entry.hdr     = !bad_size && (bytes_seen_ff == '0);
      entry.fault   = bad_size;
      entry.last    = is_last && !bad_size;
      entry.data    = bad_size ? 8'd0 : payload_byte;
      entry.profile = aac_profile;
      entry.freq    = freq_index;
      entry.chan    = (channel_config == 3'd0) ? 3'd2 : channel_config;
      entry.flen    = flen[adts_pkg::FLEN_W-1:0];
      load          = accept && !failed_ff && (bad_size || fits);
   end

   // Advance the sample counter and latch the fault
   always_comb begin
      bytes_seen_in = bytes_seen_ff;
      failed_in     = failed_ff;
      if (accept && !failed_ff) begin
         if (bad_size) begin
            failed_in = 1'b1;
         end else if (is_last) begin
            bytes_seen_in = '0;
         end else begin
            bytes_seen_in = seen_next[adts_pkg::SIZE_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bytes_seen_ff <= '0;
         failed_ff     <= 1'b0;
      end else begin
         bytes_seen_ff <= bytes_seen_in;
         failed_ff     <= failed_in;
      end
   end

endmodule

// ===== hw/rtl/adts_emit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adts_emit: work register and output register
// Holds one work entry and walks it into the output register one byte
// per cycle while it has room, inserting seven header bytes where required.
// ----------------------------------------------------------------------------
module adts_emit (
   input  logic               clock,
   input  logic               reset,
   input  logic               load,
   input  adts_pkg::work_type entry,
   output logic               take_ready,
   output logic [7:0]         rsp_tdata,   // out_byte
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic               rsp_tlast,   // frame_end
   output logic               rsp_tuser    // fault
);

   adts_pkg::work_type work_ff, work_in;
   logic               work_valid_ff, work_valid_in;
   logic [2:0]         idx_ff, idx_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [7:0]         rsp_data_ff, rsp_data_in;
   logic               rsp_last_ff, rsp_last_in;
   logic               rsp_fault_ff, rsp_fault_in;
   logic               out_free;
   logic               fire;
   logic               done;
   logic               on_payload;

   // Step through the entry while the output register has room
   always_comb begin
      out_free   = !rsp_valid_ff || rsp_tready;
      fire       = work_valid_ff && out_free;
      on_payload = !work_ff.hdr || (idx_ff == adts_pkg::HDR_LAST_IDX);
      done       = fire && on_payload;
      take_ready = !work_valid_ff || done;

      work_in       = work_ff;
      work_valid_in = work_valid_ff;
      idx_in        = idx_ff;
      if (load) begin
         work_in       = entry;
         work_valid_in = 1'b1;
         idx_in        = '0;
      end else if (done) begin
         work_valid_in = 1'b0;
      end else if (fire) begin
         idx_in = idx_ff + 3'd1;
      end
   end

   // Load the output register, drop the transaction once taken
   always_comb begin
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_fault_in = rsp_fault_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (fire) begin
         rsp_valid_in = 1'b1;
         rsp_fault_in = work_ff.fault;
         rsp_last_in  = on_payload && work_ff.last;
         rsp_data_in  = on_payload ? work_ff.data : adts_pkg::hdr_byte(work_ff, idx_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         work_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         idx_ff        <= '0;
      end else begin
         work_valid_ff <= work_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         idx_ff        <= idx_in;
      end
      work_ff      <= work_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_fault_ff <= rsp_fault_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_fault_ff;

endmodule

// ===== hw/rtl/adts_frame_wrapper.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adts_frame_wrapper: AAC raw payload to ADTS framing
// Usage: feed raw AAC payload one byte per transaction on req_, each tagged
// with the byte size of its sample. The first byte of a sample produces a
// 7-byte ADTS header followed by that byte; later bytes pass straight
// through, and the final byte of a sample carries rsp_tlast. Samples whose
// frame would exceed 8191 bytes are swallowed without output. A size of zero
// or above 1 MiB produces one transaction with rsp_tuser set and then the
// block stays silent until reset.
// Latency: two register stages, the work register and then the output
// register, between the accepting edge and the first output byte.
// Throughput: one payload byte per cycle while rsp_tready is high; during
// the seven header bytes on the single output lane, req_tready stays low.
// Reset: clears the sample count, the fault and any pending output, and
// restores the csr registers to profile 1, frequency index 4, channels 2.
// Stall: when rsp_tready is low the output register holds its byte and the
// work register holds the pending entry, so req_tready drops once it is full.
// Write csr registers only while the stream is idle.
// ----------------------------------------------------------------------------
module adts_frame_wrapper (
   input  logic        clock,
   input  logic        reset,
   input  logic [31:0] req_tdata,   // payload_byte [7:0], sample_bytes [28:8]
   input  logic        req_tvalid,
   output logic        req_tready,
   output logic [7:0]  rsp_tdata,   // out_byte [7:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic        rsp_tlast,   // frame_end
   output logic        rsp_tuser,   // fault
   input  logic        csr_we,
   input  logic [1:0]  csr_addr,
   input  logic [3:0]  csr_wdata
);

   logic [1:0]         aac_profile_ff, aac_profile_in;
   logic [3:0]         freq_index_ff, freq_index_in;
   logic [2:0]         channel_config_ff, channel_config_in;
   logic               accept;
   logic               load;
   adts_pkg::work_type entry;

   // Register writes
   always_comb begin
      aac_profile_in    = aac_profile_ff;
      freq_index_in     = freq_index_ff;
      channel_config_in = channel_config_ff;
      if (csr_we) begin
         case (csr_addr)
            adts_pkg::REG_AAC_PROFILE:    aac_profile_in    = csr_wdata[1:0];
            adts_pkg::REG_FREQ_INDEX:     freq_index_in     = csr_wdata;
            adts_pkg::REG_CHANNEL_CONFIG: channel_config_in = csr_wdata[2:0];
            default:                      ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         aac_profile_ff    <= adts_pkg::AAC_PROFILE_RST;
         freq_index_ff     <= adts_pkg::FREQ_INDEX_RST;
         channel_config_ff <= adts_pkg::CHANNEL_CONFIG_RST;
      end else begin
         aac_profile_ff    <= aac_profile_in;
         freq_index_ff     <= freq_index_in;
         channel_config_ff <= channel_config_in;
      end
   end

   assign accept = req_tvalid && req_tready;

   adts_dec u_dec (
      .clock          (clock),
      .reset          (reset),
      .accept         (accept),
      .payload_byte   (req_tdata[7:0]),
      .sample_bytes   (req_tdata[28:8]),
      .aac_profile    (aac_profile_ff),
      .freq_index     (freq_index_ff),
      .channel_config (channel_config_ff),
      .load           (load),
      .entry          (entry)
   );

   adts_emit u_emit (
      .clock      (clock),
      .reset      (reset),
      .load       (load),
      .entry      (entry),
      .take_ready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
